@@ hdl/i2cmts_pkg.sv @@
// Shared constants, codes and types of the I2C master transfer sequencer.
`timescale 1ns / 1ps
`default_nettype none

package i2cmts_pkg;

   // Default sizes of the payload store and the control byte list.
   localparam int unsigned PAYLOAD_MAX_DEF = 256;
   localparam int unsigned CTRL_MAX_DEF    = 8;

   // Fixed widths of the configuration registers.
   localparam int unsigned CTRL_BYTES_W  = 64;
   localparam int unsigned CTRL_MASK_W   = 8;
   localparam int unsigned CTRL_COUNT_W  = 4;
   localparam int unsigned PAY_LENGTH_W  = 9;
   localparam int unsigned CSR_ADDR_W    = 6;
   localparam int unsigned CSR_DATA_W    = 64;

   // Item function codes.
   typedef enum logic [1:0] {
      FUNC_LOAD  = 2'd0,
      FUNC_START = 2'd1,
      FUNC_EVENT = 2'd2
   } func_type;

   // Result status codes.
   typedef enum logic [2:0] {
      STATUS_BUSY      = 3'd0,
      STATUS_DONE      = 3'd1,
      STATUS_NAK       = 3'd2,
      STATUS_BUS_ERROR = 3'd3,
      STATUS_MC_ERROR  = 3'd4
   } status_type;

   // Configuration register indexes (byte address is eight times the index).
   typedef enum logic [2:0] {
      CFG_CTRL_BYTES       = 3'd0,
      CFG_CTRL_REPEAT_MASK = 3'd1,
      CFG_CTRL_COUNT       = 3'd2,
      CFG_PAYLOAD_LENGTH   = 3'd3,
      CFG_MASTER_CODE_MODE = 3'd4
   } cfg_index_type;

   // One result item; from_store marks a byte still to be taken from the store.
   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       from_store;
      logic       repeat_start;
      logic       stay_master;
      logic       ack_next;
      logic       rx_valid;
      logic [7:0] rx_data;
      logic [7:0] rx_position;
      status_type status;
   } rsp_type;

endpackage

`default_nettype wire

@@ hdl/i2c_master_transfer_sequencer_core.sv @@
// Top level of the I2C master transfer sequencer: item decode, payload store and result stage.
// Items pass through the decode stage and then the result register; the store read issued at
// acceptance holds the byte the result register takes when the decode stage moves on.
// Throughput: one item per cycle if rsp_stall is low; an item uses at most one store port.
// Reset (synchronous): clears positions, the master-code flag, configuration and both stages.
// Payload store not cleared; every entry must be written before it is read (not enforced).
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_transfer_sequencer_core #(
   parameter int unsigned PAYLOAD_MAX = i2cmts_pkg::PAYLOAD_MAX_DEF,
   parameter int unsigned CTRL_MAX    = i2cmts_pkg::CTRL_MAX_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Input channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_func,
   input  wire logic [7:0]  req_load_byte,
   input  wire logic        req_bus_error,
   input  wire logic        req_transfer_int,
   input  wire logic        req_master_mode,
   input  wire logic        req_last_bit_nak,
   input  wire logic        req_transmitting,
   input  wire logic        req_first_byte,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic        req_arbitration_won,
   // Result channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_tx_valid,
   output logic [7:0]       rsp_tx_byte,
   output logic             rsp_repeat_start,
   output logic             rsp_stay_master,
   output logic             rsp_ack_next,
   output logic             rsp_rx_valid,
   output logic [7:0]       rsp_rx_data,
   output logic [7:0]       rsp_rx_position,
   output logic [2:0]       rsp_status,
   // Configuration port
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [i2cmts_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [i2cmts_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [i2cmts_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                   csr_pready
);

   // Position widths: PW holds 0..PAYLOAD_MAX, AW addresses the store, LW compares lengths.
   localparam int unsigned PW = $clog2(PAYLOAD_MAX + 1);
   localparam int unsigned AW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
   localparam int unsigned LW = (PW > i2cmts_pkg::PAY_LENGTH_W) ? PW : i2cmts_pkg::PAY_LENGTH_W;
   localparam int unsigned CW = i2cmts_pkg::CTRL_COUNT_W;

   // Configuration registers.
   logic [i2cmts_pkg::CTRL_BYTES_W-1:0] ctrl_bytes_ff;
   logic [i2cmts_pkg::CTRL_MASK_W-1:0]  ctrl_repeat_mask_ff;
   logic [CW-1:0]                       ctrl_count_ff;
   logic [i2cmts_pkg::PAY_LENGTH_W-1:0] payload_length_ff;
   logic                                master_code_mode_ff;

   // Sequencer state.
   logic [CW-1:0] ctrl_position_ff, ctrl_position_in;
   logic [PW-1:0] payload_position_ff, payload_position_in;
   logic [PW-1:0] load_position_ff, load_position_in;
   logic          master_code_pending_ff, master_code_pending_in;

   // Decode stage and result stage.
   logic                p1_valid_ff, p1_valid_in;
   i2cmts_pkg::rsp_type p1_ff, p1_in;
   logic                out_valid_ff, out_valid_in;
   i2cmts_pkg::rsp_type out_ff, out_in;

   // Store port signals.
   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [7:0]    ram_wr_data;
   logic          ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   logic [7:0]    ram_rd_data;

   // Handshake.
   logic req_fire;
   logic p1_move;

   // Limits and the next byte to send.
   logic [CW-1:0] ctrl_limit;
   logic [LW-1:0] data_limit;
   logic          is_start;
   logic [CW-1:0] base_ctrl;
   logic [PW-1:0] base_pay;
   logic          send_ctrl;
   logic          send_pay;
   logic [2:0]    ctrl_sel;
   logic [7:0]    ctrl_byte;
   logic          ctrl_repeat;
   logic [PW-1:0] pay_adv;
   logic          ack_cur;
   logic          ack_adv;
   logic          rx_room;
   logic          load_room;
   logic          do_send;
   logic          csr_write;

   // ---------------------------------------------------------------------
   // Configuration port
   // ---------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_bytes_ff       <= '0;
         ctrl_repeat_mask_ff <= '0;
         ctrl_count_ff       <= '0;
         payload_length_ff   <= '0;
         master_code_mode_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_paddr[5:3])
            i2cmts_pkg::CFG_CTRL_BYTES: begin
               ctrl_bytes_ff <= csr_pwdata;
            end
            i2cmts_pkg::CFG_CTRL_REPEAT_MASK: begin
               ctrl_repeat_mask_ff <= csr_pwdata[i2cmts_pkg::CTRL_MASK_W-1:0];
            end
            i2cmts_pkg::CFG_CTRL_COUNT: begin
               ctrl_count_ff <= csr_pwdata[CW-1:0];
            end
            i2cmts_pkg::CFG_PAYLOAD_LENGTH: begin
               payload_length_ff <= csr_pwdata[i2cmts_pkg::PAY_LENGTH_W-1:0];
            end
            i2cmts_pkg::CFG_MASTER_CODE_MODE: begin
               master_code_mode_ff <= csr_pwdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      case (csr_paddr[5:3])
         i2cmts_pkg::CFG_CTRL_BYTES:       csr_prdata = ctrl_bytes_ff;
         i2cmts_pkg::CFG_CTRL_REPEAT_MASK: csr_prdata = 64'(ctrl_repeat_mask_ff);
         i2cmts_pkg::CFG_CTRL_COUNT:       csr_prdata = 64'(ctrl_count_ff);
         i2cmts_pkg::CFG_PAYLOAD_LENGTH:   csr_prdata = 64'(payload_length_ff);
         i2cmts_pkg::CFG_MASTER_CODE_MODE: csr_prdata = 64'(master_code_mode_ff);
         default:                          csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Handshake: the decode stage moves on whenever the result register frees up
   // ---------------------------------------------------------------------
   assign p1_move   = p1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = p1_valid_ff && !p1_move;
   assign req_fire  = req_valid && !req_stall;

   // ---------------------------------------------------------------------
   // Limits and next-byte selection (a start restarts from position zero)
   // ---------------------------------------------------------------------
   always_comb begin
      ctrl_limit = (ctrl_count_ff > CW'(CTRL_MAX)) ? CW'(CTRL_MAX) : ctrl_count_ff;
      data_limit = (LW'(payload_length_ff) > LW'(PAYLOAD_MAX)) ? LW'(PAYLOAD_MAX)
                                                               : LW'(payload_length_ff);
      is_start    = (req_func == i2cmts_pkg::FUNC_START);
      base_ctrl   = is_start ? '0 : ctrl_position_ff;
      base_pay    = is_start ? '0 : payload_position_ff;
      send_ctrl   = (base_ctrl < ctrl_limit);
      send_pay    = !send_ctrl && (LW'(base_pay) < data_limit);
      ctrl_sel    = base_ctrl[2:0];
      ctrl_byte   = ctrl_bytes_ff[8*ctrl_sel +: 8];
      ctrl_repeat = ctrl_repeat_mask_ff[ctrl_sel];
      // Receive bookkeeping: ACK unless the following byte would be the last one.
      pay_adv   = payload_position_ff + PW'(1);
      ack_cur   = !(({1'b0, LW'(payload_position_ff)} + (LW+1)'(1)) >= {1'b0, data_limit});
      ack_adv   = !(({1'b0, LW'(pay_adv)} + (LW+1)'(1)) >= {1'b0, data_limit});
      rx_room   = (LW'(payload_position_ff) < data_limit);
      load_room = (load_position_ff < PW'(PAYLOAD_MAX));
   end

   // ---------------------------------------------------------------------
   // Item decode: next state, store access and the partial result
   // ---------------------------------------------------------------------
   always_comb begin
      ctrl_position_in       = ctrl_position_ff;
      payload_position_in    = payload_position_ff;
      load_position_in       = load_position_ff;
      master_code_pending_in = master_code_pending_ff;
      p1_in                  = '0;
      ram_wr_en              = 1'b0;
      ram_wr_addr            = load_position_ff[AW-1:0];
      ram_wr_data            = req_load_byte;
      ram_rd_en              = 1'b0;
      ram_rd_addr            = base_pay[AW-1:0];
      do_send                = 1'b0;

      case (req_func)
         i2cmts_pkg::FUNC_LOAD: begin
            if (load_room) begin
               ram_wr_en        = req_fire;
               load_position_in = load_position_ff + PW'(1);
            end
         end
         i2cmts_pkg::FUNC_START: begin
            ctrl_position_in       = '0;
            payload_position_in    = '0;
            load_position_in       = '0;
            master_code_pending_in = master_code_mode_ff;
            do_send                = 1'b1;
         end
         i2cmts_pkg::FUNC_EVENT: begin
            if (req_bus_error) begin
               // A bus error ends the transfer; its code tells the master-code phase apart.
               master_code_pending_in = 1'b0;
               p1_in.status = (master_code_pending_ff && !req_last_bit_nak)
                            ? i2cmts_pkg::STATUS_MC_ERROR : i2cmts_pkg::STATUS_BUS_ERROR;
            end else if (req_transfer_int) begin
               if (!req_master_mode) begin
                  // Slave mode is not handled: report nothing and keep state.
                  p1_in.status = i2cmts_pkg::STATUS_BUSY;
               end else if (master_code_pending_ff) begin
                  master_code_pending_in = 1'b0;
                  if (!req_arbitration_won) begin
                     p1_in.status = i2cmts_pkg::STATUS_DONE;
                  end else begin
                     do_send = 1'b1;
                  end
               end else if (req_transmitting) begin
                  if (req_last_bit_nak) begin
                     p1_in.status = i2cmts_pkg::STATUS_NAK;
                  end else begin
                     do_send = 1'b1;
                  end
               end else if (req_first_byte) begin
                  p1_in.ack_next    = ack_cur;
                  p1_in.stay_master = 1'b1;
               end else if (!rx_room) begin
                  p1_in.status = i2cmts_pkg::STATUS_DONE;
               end else begin
                  // Store the received byte and move to the next payload position.
                  ram_wr_en           = req_fire;
                  ram_wr_addr         = payload_position_ff[AW-1:0];
                  ram_wr_data         = req_rx_byte;
                  p1_in.rx_valid      = 1'b1;
                  p1_in.rx_data       = req_rx_byte;
                  p1_in.rx_position   = 8'(payload_position_ff);
                  payload_position_in = pay_adv;
                  p1_in.ack_next      = ack_adv;
                  if (LW'(pay_adv) >= data_limit) begin
                     p1_in.status = i2cmts_pkg::STATUS_DONE;
                  end else begin
                     p1_in.stay_master = 1'b1;
                  end
               end
            end else begin
               p1_in.stay_master = req_master_mode;
            end
         end
         default: begin
         end
      endcase

      // Send the next control or payload byte, or stop when none is left.
      if (do_send) begin
         if (send_ctrl) begin
            p1_in.tx_valid     = 1'b1;
            p1_in.tx_byte      = ctrl_byte;
            p1_in.repeat_start = ctrl_repeat;
            p1_in.stay_master  = 1'b1;
            ctrl_position_in   = base_ctrl + CW'(1);
         end else if (send_pay) begin
            p1_in.tx_valid      = 1'b1;
            p1_in.from_store    = 1'b1;
            p1_in.stay_master   = 1'b1;
            ram_rd_en           = req_fire;
            payload_position_in = base_pay + PW'(1);
         end else begin
            p1_in.stay_master = 1'b0;
            p1_in.status      = i2cmts_pkg::STATUS_DONE;
         end
      end
   end

   // State registers advance only on an accepted transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_position_ff       <= '0;
         payload_position_ff    <= '0;
         load_position_ff       <= '0;
         master_code_pending_ff <= 1'b0;
      end else if (req_fire) begin
         ctrl_position_ff       <= ctrl_position_in;
         payload_position_ff    <= payload_position_in;
         load_position_ff       <= load_position_in;
         master_code_pending_ff <= master_code_pending_in;
      end
   end

   // ---------------------------------------------------------------------
   // Payload store
   // ---------------------------------------------------------------------
   i2cmts_ram #(
      .WIDTH (8),
      .DEPTH (PAYLOAD_MAX)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------------
   // Decode stage and result register
   // ---------------------------------------------------------------------
   always_comb begin
      p1_valid_in  = p1_valid_ff;
      out_valid_in = out_valid_ff;
      out_in       = p1_ff;
      if (p1_ff.from_store) begin
         out_in.tx_byte = ram_rd_data;
      end
      if (p1_move) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
      if (req_fire) begin
         p1_valid_in = 1'b1;
      end else if (p1_move) begin
         p1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff  <= p1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         p1_ff <= p1_in;
      end
      if (p1_move) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_tx_valid     = out_ff.tx_valid;
   assign rsp_tx_byte      = out_ff.tx_byte;
   assign rsp_repeat_start = out_ff.repeat_start;
   assign rsp_stay_master  = out_ff.stay_master;
   assign rsp_ack_next     = out_ff.ack_next;
   assign rsp_rx_valid     = out_ff.rx_valid;
   assign rsp_rx_data      = out_ff.rx_data;
   assign rsp_rx_position  = out_ff.rx_position;
   assign rsp_status       = out_ff.status;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_tx_keeps_bus: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tx_valid |-> rsp_stay_master && rsp_status == i2cmts_pkg::STATUS_BUSY)
      else $error("transmit result without bus ownership or with a final status");

   a_tx_rx_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_tx_valid && rsp_rx_valid))
      else $error("result both transmits and receives");

   a_fire_fills_stage: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> p1_valid_ff)
      else $error("accepted transfer lost before the result stage");

   a_positions_bounded: assert property (@(posedge clock) disable iff (reset)
      load_position_ff <= PW'(PAYLOAD_MAX) && payload_position_ff <= PW'(PAYLOAD_MAX)
      && ctrl_position_ff <= CW'(CTRL_MAX))
      else $error("sequencer position beyond its limit");

endmodule

`default_nettype wire

@@ hdl/i2cmts_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module i2cmts_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256,
   localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds until the next enabled read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ test/tb_i2c_master_transfer_sequencer_core.sv @@
// Self-checking testbench for the I2C master transfer sequencer core.
`timescale 1ns / 1ps

module tb_i2c_master_transfer_sequencer_core;

   // The function code that the block ignores has no name in the package.
   localparam logic [1:0] FUNC_RESERVED = 2'd3;
   localparam int STORE_DEPTH = i2cmts_pkg::PAYLOAD_MAX_DEF;

   // One input transfer and one result transfer as the bench sees them.
   typedef struct packed {
      logic [1:0] func;
      logic [7:0] load_byte;
      logic       bus_error;
      logic       transfer_int;
      logic       master_mode;
      logic       last_bit_nak;
      logic       transmitting;
      logic       first_byte;
      logic [7:0] rx_byte;
      logic       arbitration_won;
   } seq_item_type;

   typedef struct packed {
      logic                   tx_valid;
      logic [7:0]             tx_byte;
      logic                   repeat_start;
      logic                   stay_master;
      logic                   ack_next;
      logic                   rx_valid;
      logic [7:0]             rx_data;
      logic [7:0]             rx_position;
      i2cmts_pkg::status_type status;
   } bus_action_type;

   // Clock, reset and all block inputs start at known values.
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic [1:0] req_func = '0;
   logic [7:0] req_load_byte = '0;
   logic req_bus_error = 1'b0;
   logic req_transfer_int = 1'b0;
   logic req_master_mode = 1'b0;
   logic req_last_bit_nak = 1'b0;
   logic req_transmitting = 1'b0;
   logic req_first_byte = 1'b0;
   logic [7:0] req_rx_byte = '0;
   logic req_arbitration_won = 1'b0;
   logic rsp_stall = 1'b0;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [i2cmts_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [i2cmts_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;

   logic req_stall;
   logic rsp_valid;
   logic rsp_tx_valid;
   logic [7:0] rsp_tx_byte;
   logic rsp_repeat_start;
   logic rsp_stay_master;
   logic rsp_ack_next;
   logic rsp_rx_valid;
   logic [7:0] rsp_rx_data;
   logic [7:0] rsp_rx_position;
   logic [2:0] rsp_status;
   logic [i2cmts_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   // Register copies and sequencer state kept by the predictor.
   logic [63:0] cfg_ctrl_bytes = '0;
   logic [7:0] cfg_repeat_mask = '0;
   logic [3:0] cfg_ctrl_count = '0;
   logic [8:0] cfg_payload_length = '0;
   logic cfg_mc_mode = 1'b0;
   int ctrl_pos = 0;
   int pay_pos = 0;
   int load_pos = 0;
   logic mc_pending = 1'b0;
   logic [7:0] seq_store [0:STORE_DEPTH-1];

   bus_action_type expected_actions [$];
   logic transfer_active = 1'b0;
   logic quiet_sender = 1'b0;
   int items_accepted = 0;
   int results_checked = 0;
   int transfers_run = 0;
   int settings_used = 0;
   int mismatch_count = 0;

   i2c_master_transfer_sequencer_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_load_byte(req_load_byte),
      .req_bus_error(req_bus_error),
      .req_transfer_int(req_transfer_int),
      .req_master_mode(req_master_mode),
      .req_last_bit_nak(req_last_bit_nak),
      .req_transmitting(req_transmitting),
      .req_first_byte(req_first_byte),
      .req_rx_byte(req_rx_byte),
      .req_arbitration_won(req_arbitration_won),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_tx_valid(rsp_tx_valid),
      .rsp_tx_byte(rsp_tx_byte),
      .rsp_repeat_start(rsp_repeat_start),
      .rsp_stay_master(rsp_stay_master),
      .rsp_ack_next(rsp_ack_next),
      .rsp_rx_valid(rsp_rx_valid),
      .rsp_rx_data(rsp_rx_data),
      .rsp_rx_position(rsp_rx_position),
      .rsp_status(rsp_status),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // Free-running 2 ns clock.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Effective limits after clamping the count and length registers.
   function automatic int ctrl_in_use();
      return (cfg_ctrl_count > i2cmts_pkg::CTRL_MAX_DEF) ? i2cmts_pkg::CTRL_MAX_DEF
                                                         : int'(cfg_ctrl_count);
   endfunction

   function automatic int payload_in_use();
      return (cfg_payload_length > STORE_DEPTH) ? STORE_DEPTH : int'(cfg_payload_length);
   endfunction

   function automatic logic ack_for_next_byte();
      return (pay_pos + 1 >= payload_in_use()) ? 1'b0 : 1'b1;
   endfunction

   // Sends the next control or payload byte, or stops when none is left.
   function automatic bus_action_type next_byte_action();
      bus_action_type a;
      a = '0;
      if (ctrl_pos < ctrl_in_use()) begin
         a.tx_valid = 1'b1;
         a.tx_byte = cfg_ctrl_bytes[8*ctrl_pos +: 8];
         a.repeat_start = cfg_repeat_mask[ctrl_pos];
         a.stay_master = 1'b1;
         ctrl_pos++;
      end else if (pay_pos < payload_in_use()) begin
         a.tx_valid = 1'b1;
         a.tx_byte = seq_store[pay_pos];
         a.stay_master = 1'b1;
         pay_pos++;
      end else begin
         a.status = i2cmts_pkg::STATUS_DONE;
      end
      return a;
   endfunction

   // Works out the result of one accepted item and advances the state copy.
   function automatic bus_action_type predict_bus_action(input seq_item_type it);
      bus_action_type a;
      a = '0;
      case (it.func)
         i2cmts_pkg::FUNC_LOAD: begin
            if (load_pos < STORE_DEPTH) begin
               seq_store[load_pos] = it.load_byte;
               load_pos++;
            end
         end
         i2cmts_pkg::FUNC_START: begin
            ctrl_pos = 0;
            pay_pos = 0;
            load_pos = 0;
            mc_pending = cfg_mc_mode;
            a = next_byte_action();
         end
         i2cmts_pkg::FUNC_EVENT: begin
            if (it.bus_error) begin
               if (mc_pending && !it.last_bit_nak) a.status = i2cmts_pkg::STATUS_MC_ERROR;
               else a.status = i2cmts_pkg::STATUS_BUS_ERROR;
               mc_pending = 1'b0;
            end else if (it.transfer_int) begin
               if (!it.master_mode) begin
                  // Slave mode is not handled; nothing changes.
               end else if (mc_pending) begin
                  mc_pending = 1'b0;
                  if (!it.arbitration_won) a.status = i2cmts_pkg::STATUS_DONE;
                  else a = next_byte_action();
               end else if (it.transmitting) begin
                  if (it.last_bit_nak) a.status = i2cmts_pkg::STATUS_NAK;
                  else a = next_byte_action();
               end else if (it.first_byte) begin
                  a.ack_next = ack_for_next_byte();
                  a.stay_master = 1'b1;
               end else if (pay_pos >= payload_in_use()) begin
                  a.status = i2cmts_pkg::STATUS_DONE;
               end else begin
                  seq_store[pay_pos] = it.rx_byte;
                  a.rx_valid = 1'b1;
                  a.rx_data = it.rx_byte;
                  a.rx_position = 8'(pay_pos);
                  pay_pos++;
                  if (pay_pos >= payload_in_use()) a.status = i2cmts_pkg::STATUS_DONE;
                  else a.stay_master = 1'b1;
                  a.ack_next = ack_for_next_byte();
               end
            end else begin
               a.stay_master = it.master_mode;
            end
         end
         default: begin
            // The reserved code is ignored.
         end
      endcase
      return a;
   endfunction

   // Idle lengths: mostly short, now and then long.
   function automatic int gap_length();
      if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic seq_item_type random_item();
      seq_item_type it;
      it.func = 2'($urandom_range(0, 3));
      it.load_byte = 8'($urandom_range(0, 255));
      it.bus_error = 1'($urandom_range(0, 1));
      it.transfer_int = 1'($urandom_range(0, 1));
      it.master_mode = 1'($urandom_range(0, 1));
      it.last_bit_nak = 1'($urandom_range(0, 1));
      it.transmitting = 1'($urandom_range(0, 1));
      it.first_byte = 1'($urandom_range(0, 1));
      it.rx_byte = 8'($urandom_range(0, 255));
      it.arbitration_won = 1'($urandom_range(0, 1));
      return it;
   endfunction

   function automatic seq_item_type plain_item(input logic [1:0] code);
      seq_item_type it;
      it = random_item();
      it.func = code;
      return it;
   endfunction

   // A completed-byte event while master; the other fields stay random.
   function automatic seq_item_type bus_event(input logic trx, input logic nak, input logic fbt);
      seq_item_type it;
      it = plain_item(i2cmts_pkg::FUNC_EVENT);
      it.bus_error = 1'b0;
      it.transfer_int = 1'b1;
      it.master_mode = 1'b1;
      it.transmitting = trx;
      it.last_bit_nak = nak;
      it.first_byte = fbt;
      return it;
   endfunction

   // Drives one item after an optional gap and waits until it is accepted.
   task automatic send_item(input seq_item_type it);
      bus_action_type want;
      int gap;
      gap = (quiet_sender || $urandom_range(0, 1)) ? 0 : gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= it.func;
      req_load_byte <= it.load_byte;
      req_bus_error <= it.bus_error;
      req_transfer_int <= it.transfer_int;
      req_master_mode <= it.master_mode;
      req_last_bit_nak <= it.last_bit_nak;
      req_transmitting <= it.transmitting;
      req_first_byte <= it.first_byte;
      req_rx_byte <= it.rx_byte;
      req_arbitration_won <= it.arbitration_won;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      want = predict_bus_action(it);
      expected_actions.push_back(want);
      items_accepted++;
      if (it.func == i2cmts_pkg::FUNC_START || it.func == i2cmts_pkg::FUNC_EVENT)
         transfer_active = want.stay_master && (want.status == i2cmts_pkg::STATUS_BUSY);
   endtask

   // Stops sending, drains all results, then lets the pipeline settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_actions.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // One register write: setup cycle, then access cycle until pready.
   // The select stays up for a following write; set_config drops it at the end.
   task automatic write_csr(input i2cmts_pkg::cfg_index_type idx, input logic [63:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         i2cmts_pkg::CFG_CTRL_BYTES: cfg_ctrl_bytes = value;
         i2cmts_pkg::CFG_CTRL_REPEAT_MASK: cfg_repeat_mask = value[7:0];
         i2cmts_pkg::CFG_CTRL_COUNT: cfg_ctrl_count = value[3:0];
         i2cmts_pkg::CFG_PAYLOAD_LENGTH: cfg_payload_length = value[8:0];
         i2cmts_pkg::CFG_MASTER_CODE_MODE: cfg_mc_mode = value[0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [63:0] bytes, input logic [7:0] mask,
                             input logic [3:0] count, input logic [8:0] len,
                             input logic mc);
      wait_idle();
      write_csr(i2cmts_pkg::CFG_CTRL_BYTES, bytes);
      write_csr(i2cmts_pkg::CFG_CTRL_REPEAT_MASK, {56'd0, mask});
      write_csr(i2cmts_pkg::CFG_CTRL_COUNT, {60'd0, count});
      write_csr(i2cmts_pkg::CFG_PAYLOAD_LENGTH, {55'd0, len});
      write_csr(i2cmts_pkg::CFG_MASTER_CODE_MODE, {63'd0, mc});
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      settings_used++;
   endtask

   // Fills every store entry, then overflows it; the extra loads are dropped.
   task automatic test_store_full();
      repeat (STORE_DEPTH + 4) send_item(plain_item(i2cmts_pkg::FUNC_LOAD));
   endtask

   // Events outside a transfer: empty start, reserved code, slave mode, no cause, bus error.
   task automatic test_idle_events();
      seq_item_type it;
      send_item(plain_item(i2cmts_pkg::FUNC_START));
      send_item(plain_item(FUNC_RESERVED));
      it = bus_event(1'b1, 1'b0, 1'b0);
      it.master_mode = 1'b0;
      send_item(it);
      it.transfer_int = 1'b0;
      send_item(it);
      it.master_mode = 1'b1;
      send_item(it);
      it.bus_error = 1'b1;
      send_item(it);
   endtask

   // Control bytes with a repeated start, payload bytes, then a NAK stop.
   task automatic test_transmit();
      set_config(64'h0123_4567_89AB_CDEF, 8'b0000_0010, 4'd3, 9'd2, 1'b0);
      send_item(plain_item(i2cmts_pkg::FUNC_START));
      while (transfer_active) send_item(bus_event(1'b1, 1'b0, 1'b0));
      send_item(plain_item(i2cmts_pkg::FUNC_START));
      send_item(bus_event(1'b1, 1'b1, 1'b0));
   endtask

   // Master-code phase: error codes, lost arbitration and won arbitration.
   task automatic test_master_code();
      seq_item_type it;
      set_config(64'hFEDC_BA98_7654_3210, 8'b1000_0001, 4'd2, 9'd1, 1'b1);
      send_item(plain_item(i2cmts_pkg::FUNC_START));
      it = bus_event(1'b1, 1'b0, 1'b0);
      it.bus_error = 1'b1;
      send_item(it);
      send_item(plain_item(i2cmts_pkg::FUNC_START));
      it.last_bit_nak = 1'b1;
      send_item(it);
      send_item(plain_item(i2cmts_pkg::FUNC_START));
      it = bus_event(1'b1, 1'b0, 1'b0);
      it.arbitration_won = 1'b0;
      send_item(it);
      send_item(plain_item(i2cmts_pkg::FUNC_START));
      it.arbitration_won = 1'b1;
      send_item(it);
      while (transfer_active) send_item(bus_event(1'b1, 1'b0, 1'b0));
   endtask

   // Address byte, first-byte event, received bytes, then a read past the end.
   task automatic test_receive();
      set_config(64'h0000_0000_0000_00A1, 8'h00, 4'd1, 9'd3, 1'b0);
      send_item(plain_item(i2cmts_pkg::FUNC_START));
      send_item(bus_event(1'b0, 1'b0, 1'b1));
      repeat (4) send_item(bus_event(1'b0, 1'b0, 1'b0));
      set_config(64'h0000_0000_0000_0051, 8'h01, 4'd1, 9'd1, 1'b0);
      send_item(plain_item(i2cmts_pkg::FUNC_START));
      send_item(bus_event(1'b0, 1'b0, 1'b1));
      send_item(bus_event(1'b0, 1'b0, 1'b0));
   endtask

   // Count and length beyond their limits are clamped.
   task automatic test_register_extremes();
      set_config('1, 8'hFF, 4'd15, 9'd511, 1'b1);
      send_item(plain_item(i2cmts_pkg::FUNC_START));
      repeat (12) send_item(bus_event(1'b1, 1'b0, 1'b0));
   endtask

   // One transfer of random direction with random content and some noise.
   task automatic run_transfer();
      seq_item_type it;
      logic receive;
      logic first_done;
      int r;
      int steps;
      receive = 1'($urandom_range(0, 1));
      first_done = 1'b0;
      quiet_sender = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(0, 3)) send_item(plain_item(i2cmts_pkg::FUNC_LOAD));
      send_item(plain_item(i2cmts_pkg::FUNC_START));
      steps = 0;
      while (transfer_active && steps < 700) begin
         r = $urandom_range(0, 99);
         it = bus_event(1'b1, 1'b0, 1'b0);
         if (r < 8) begin
            it = random_item();
         end else if (r < 11) begin
            it.bus_error = 1'b1;
            it.last_bit_nak = 1'($urandom_range(0, 1));
         end else if (r < 13) begin
            it.transfer_int = 1'($urandom_range(0, 1));
            it.master_mode = it.transfer_int ? 1'b0 : 1'($urandom_range(0, 1));
         end else if (mc_pending) begin
            it.arbitration_won = ($urandom_range(0, 5) != 0);
         end else if (!receive || ctrl_pos < ctrl_in_use()) begin
            it.last_bit_nak = ($urandom_range(0, 19) == 0);
         end else if (!first_done) begin
            it.transmitting = 1'b0;
            it.first_byte = 1'b1;
            first_done = 1'b1;
         end else begin
            it.transmitting = 1'b0;
            it.first_byte = 1'b0;
         end
         send_item(it);
         steps++;
      end
      transfers_run++;
   endtask

   // Random phases, each under a new register setting.
   task automatic test_random();
      logic [63:0] bytes;
      logic [3:0] count;
      logic [8:0] len;
      int r;
      int base;
      int phase_start;
      base = items_accepted;
      while (items_accepted - base < 600) begin
         bytes = {$urandom, $urandom};
         if ($urandom_range(0, 7) == 0) bytes = $urandom_range(0, 1) ? '1 : '0;
         r = $urandom_range(0, 99);
         if (r < 15) count = 4'd0;
         else if (r < 25) count = 4'($urandom_range(9, 15));
         else count = 4'($urandom_range(1, 8));
         r = $urandom_range(0, 99);
         if (r < 70) len = 9'($urandom_range(0, 8));
         else if (r < 92) len = 9'($urandom_range(9, 40));
         else len = $urandom_range(0, 1) ? 9'd256 : 9'($urandom_range(255, 511));
         set_config(bytes, 8'($urandom_range(0, 255)), count, len,
                    ($urandom_range(0, 2) == 0));
         phase_start = items_accepted;
         while (items_accepted - phase_start < 80) run_transfer();
      end
      quiet_sender = 1'b0;
   endtask

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      if (mismatch_count < 50)
         $display("%0t: mismatch in %s: got %0h, expected %0h (result %0d)",
                  $realtime, what, got, want, results_checked);
      mismatch_count++;
   endtask

   // Random result-side stalls with long stretches of none.
   initial begin
      forever begin
         repeat ($urandom_range(0, 40)) @(posedge clock);
         @(posedge clock);
         rsp_stall <= 1'b1;
         repeat (gap_length()) @(posedge clock);
         rsp_stall <= 1'b0;
      end
   end

   // Each result transfer is checked against the oldest prediction.
   always @(posedge clock) begin : check_results
      bus_action_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_actions.size() == 0) begin
            report_mismatch("unexpected result", 8'(rsp_status), 8'd0);
         end else begin
            want = expected_actions.pop_front();
            if (rsp_tx_valid !== want.tx_valid)
               report_mismatch("tx_valid", 8'(rsp_tx_valid), 8'(want.tx_valid));
            if (rsp_tx_byte !== want.tx_byte)
               report_mismatch("tx_byte", rsp_tx_byte, want.tx_byte);
            if (rsp_repeat_start !== want.repeat_start)
               report_mismatch("repeat_start", 8'(rsp_repeat_start), 8'(want.repeat_start));
            if (rsp_stay_master !== want.stay_master)
               report_mismatch("stay_master", 8'(rsp_stay_master), 8'(want.stay_master));
            if (rsp_ack_next !== want.ack_next)
               report_mismatch("ack_next", 8'(rsp_ack_next), 8'(want.ack_next));
            if (rsp_rx_valid !== want.rx_valid)
               report_mismatch("rx_valid", 8'(rsp_rx_valid), 8'(want.rx_valid));
            if (rsp_rx_data !== want.rx_data)
               report_mismatch("rx_data", rsp_rx_data, want.rx_data);
            if (rsp_rx_position !== want.rx_position)
               report_mismatch("rx_position", rsp_rx_position, want.rx_position);
            if (rsp_status !== want.status)
               report_mismatch("status", 8'(rsp_status), 8'(want.status));
            results_checked++;
         end
      end
   end

   // Watchdog for a hung handshake or missing results.
   initial begin
      #2000000;
      $display("Timeout with %0d results outstanding", expected_actions.size());
      $display("Simulation FAILED");
      $finish;
   end

   // Test sequence.
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_store_full();
      test_idle_events();
      test_transmit();
      test_master_code();
      test_receive();
      test_register_extremes();
      test_random();
      wait_idle();
      $display("Ran %0d items over %0d random transfers and %0d register settings.",
               items_accepted, transfers_run, settings_used);
      $display("Checked %0d results; %0d field mismatches.", results_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hdl/i2cmts_pkg.sv
hdl/i2cmts_ram.sv
hdl/i2c_master_transfer_sequencer_core.sv
test/tb_i2c_master_transfer_sequencer_core.sv
